FILE: hw/rtl/fcr_pkg.sv
// Shared types, codes and helpers for the framed command receiver.
// No dependencies; the parser, mixer, top level and bench files import this package.
package fcr_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h53;
	localparam logic [7:0] HDR_SECOND = 8'h57;

	localparam int MIX_W = 27;
	localparam int STERM_W = 25;
	localparam int TTERM_W = 17;

	typedef enum logic [2:0] {
		PH_HUNT_S,
		PH_WAIT_W,
		PH_BYTE0,
		PH_BYTE1,
		PH_BYTE2,
		PH_BYTE3,
		PH_SUM
	} phase_t;

	typedef enum logic [1:0] {
		CFG_BASE_DUTY,
		CFG_SPEED_GAIN,
		CFG_TURN_GAIN
	} cfg_idx_t;

	typedef struct packed {
		logic              ok;
		logic              bad;
		logic signed [7:0] dir;
		logic signed [7:0] spd;
		logic signed [7:0] hgt;
		logic signed [7:0] ang;
	} parse_res_t;

	typedef struct packed {
		logic [15:0] base_duty;
		logic [15:0] speed_gain;
		logic [7:0]  turn_gain;
	} mix_cfg_t;

	typedef struct packed {
		parse_res_t  prs;
		logic [15:0] a_fwd;
		logic [15:0] a_rev;
		logic [15:0] b_fwd;
		logic [15:0] b_rev;
	} out_res_t;

	function automatic logic [15:0] clamp16(input logic signed [MIX_W-1:0] v);
		logic [15:0] r;
		if (v[MIX_W-1]) begin
			r = 16'h0000;
		end else if (|v[MIX_W-2:16]) begin
			r = 16'hFFFF;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/fcr_stream_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on nothing; used by the top level.
interface fcr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcr_out_if;
	logic              valid;
	logic              ready;
	logic              frame_accepted;
	logic              checksum_bad;
	logic signed [7:0] cmd_direction;
	logic signed [7:0] cmd_speed;
	logic signed [7:0] cmd_height;
	logic signed [7:0] cmd_angle;
	logic [15:0]       motor_a_forward;
	logic [15:0]       motor_a_reverse;
	logic [15:0]       motor_b_forward;
	logic [15:0]       motor_b_reverse;

	modport source (
		output valid, frame_accepted, checksum_bad,
		output cmd_direction, cmd_speed, cmd_height, cmd_angle,
		output motor_a_forward, motor_a_reverse, motor_b_forward, motor_b_reverse,
		input ready
	);
	modport sink (
		input valid, frame_accepted, checksum_bad,
		input cmd_direction, cmd_speed, cmd_height, cmd_angle,
		input motor_a_forward, motor_a_reverse, motor_b_forward, motor_b_reverse,
		output ready
	);
endinterface

FILE: hw/rtl/fcr_parser.sv
// Frame parser: header hunt, payload capture, checksum and command registers.
// Depends on fcr_pkg.
module fcr_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	output fcr_pkg::parse_res_t res
);
	import fcr_pkg::*;

	phase_t     phase_q;
	phase_t     phase_nx;
	logic [7:0] payload_q [4];
	logic [7:0] dir_q;
	logic [7:0] spd_q;
	logic [7:0] hgt_q;
	logic [7:0] ang_q;
	logic [7:0] sum;
	logic [1:0] slot;
	logic       is_byte;
	logic       ok;
	logic       bad;

	assign sum  = payload_q[0] + payload_q[1] + payload_q[2] + payload_q[3];
	assign slot = 2'(3'(phase_q) - 3'(PH_BYTE0));

	always_comb begin
		phase_nx = PH_HUNT_S;
		unique case (phase_q) inside
			PH_HUNT_S: phase_nx = (rx_byte == HDR_FIRST) ? PH_WAIT_W : PH_HUNT_S;
			PH_WAIT_W: begin
				if (rx_byte == HDR_SECOND) begin
					phase_nx = PH_BYTE0;
				end else if (rx_byte == HDR_FIRST) begin
					phase_nx = PH_WAIT_W;
				end else begin
					phase_nx = PH_HUNT_S;
				end
			end
			PH_BYTE0, PH_BYTE1, PH_BYTE2, PH_BYTE3: phase_nx = phase_t'(3'(phase_q) + 3'd1);
			PH_SUM:  phase_nx = PH_HUNT_S;
			default: phase_nx = PH_HUNT_S;
		endcase
	end

	always_comb begin
		is_byte = 1'b0;
		ok      = 1'b0;
		bad     = 1'b0;
		unique case (phase_q) inside
			PH_BYTE0, PH_BYTE1, PH_BYTE2, PH_BYTE3: is_byte = 1'b1;
			PH_SUM: begin
				ok  = (sum == rx_byte);
				bad = (sum != rx_byte);
			end
			default: is_byte = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_S;
			dir_q   <= '0;
			spd_q   <= '0;
			hgt_q   <= '0;
			ang_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nx;
			if (ok) begin
				dir_q <= payload_q[0];
				spd_q <= payload_q[1];
				hgt_q <= payload_q[2];
				ang_q <= payload_q[3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_byte) begin
			payload_q[slot] <= rx_byte;
		end
	end

	assign res.ok  = accept && ok;
	assign res.bad = accept && bad;
	assign res.dir = ok ? payload_q[0] : dir_q;
	assign res.spd = ok ? payload_q[1] : spd_q;
	assign res.hgt = ok ? payload_q[2] : hgt_q;
	assign res.ang = ok ? payload_q[3] : ang_q;

endmodule

FILE: hw/rtl/fcr_mixer.sv
// Differential-drive mixer: gain products in stage 1, sums and clamps into
// the result register. Depends on fcr_pkg.
module fcr_mixer (
	input  logic                clk,
	input  logic                load_s1,
	input  logic                load_out,
	input  fcr_pkg::parse_res_t prs,
	input  fcr_pkg::mix_cfg_t   cfg,
	output fcr_pkg::out_res_t   res
);
	import fcr_pkg::*;

	logic signed [STERM_W-1:0] spd_x;
	logic signed [STERM_W-1:0] sgain_x;
	logic signed [TTERM_W-1:0] dir_x;
	logic signed [TTERM_W-1:0] tgain_x;
	logic signed [STERM_W-1:0] sterm;
	logic signed [TTERM_W-1:0] tterm;

	parse_res_t                prs_s1;
	logic signed [STERM_W-1:0] sterm_s1;
	logic signed [TTERM_W-1:0] tterm_s1;

	logic signed [MIX_W-1:0] base_w;
	logic signed [MIX_W-1:0] s_w;
	logic signed [MIX_W-1:0] t_w;
	logic [15:0]             fwd_pp;
	logic [15:0]             fwd_pm;
	logic [15:0]             rev_np;
	logic [15:0]             rev_nm;
	logic [15:0]             spin_p;
	logic [15:0]             spin_m;
	out_res_t                res_nx;
	out_res_t                res_q;

	assign spd_x   = {{(STERM_W-8){prs.spd[7]}}, prs.spd};
	assign sgain_x = {{(STERM_W-16){1'b0}}, cfg.speed_gain};
	assign dir_x   = {{(TTERM_W-8){prs.dir[7]}}, prs.dir};
	assign tgain_x = {{(TTERM_W-8){1'b0}}, cfg.turn_gain};
	assign sterm   = spd_x * sgain_x;
	assign tterm   = dir_x * tgain_x;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			prs_s1   <= prs;
			sterm_s1 <= sterm;
			tterm_s1 <= tterm;
		end
	end

	assign base_w = {{(MIX_W-16){1'b0}}, cfg.base_duty};
	assign s_w    = {{(MIX_W-STERM_W){sterm_s1[STERM_W-1]}}, sterm_s1};
	assign t_w    = {{(MIX_W-TTERM_W){tterm_s1[TTERM_W-1]}}, tterm_s1};

	assign fwd_pp = clamp16(base_w + s_w + t_w);
	assign fwd_pm = clamp16(base_w + s_w - t_w);
	assign rev_np = clamp16(base_w - s_w + t_w);
	assign rev_nm = clamp16(base_w - s_w - t_w);
	assign spin_p = clamp16(base_w + t_w);
	assign spin_m = clamp16(base_w - t_w);

	always_comb begin
		res_nx       = '0;
		res_nx.prs   = prs_s1;
		if (prs_s1.spd != 8'sd0) begin
			if (!prs_s1.spd[7]) begin
				res_nx.a_fwd = fwd_pp;
				res_nx.b_fwd = fwd_pm;
			end else begin
				res_nx.a_rev = rev_np;
				res_nx.b_rev = rev_nm;
			end
		end else if (prs_s1.dir != 8'sd0) begin
			if (!prs_s1.dir[7]) begin
				res_nx.a_rev = spin_p;
				res_nx.b_fwd = spin_p;
			end else begin
				res_nx.a_fwd = spin_m;
				res_nx.b_rev = spin_m;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= res_nx;
		end
	end

	assign res = res_q;

endmodule

FILE: hw/rtl/framed_command_receiver_drive_mixer_top.sv
// Framed command receiver with differential-drive mixer, top level.
// Depends on fcr_pkg, fcr_stream_if, fcr_parser and fcr_mixer.
//
// in_ch carries one received byte per item. The parser hunts for the header
// 'S','W', takes four signed payload bytes and a checksum byte, and latches
// direction, speed, height and angle when the 8-bit sum matches.
// out_ch returns exactly one item per input item: the frame flags, the
// latched commands after that byte, and four clamped motor compare values.
// Configuration is written through cfg_we/cfg_index/cfg_data while the
// block is idle: index 0 base_duty, 1 speed_gain, 2 turn_gain.
//
// An accepted item is registered in stage 1, then moves into the output
// register, from which it is offered on out_ch. One item is accepted every
// cycle unless out_ch stalls with both stages full. The gain multipliers sit
// in the first stage, the sums and clamps feed the output register.
// Reset clears the parser to header hunt, zeroes the command registers and
// configuration, and empties both stages. When out_ch stalls, the stages
// fill and in_ch.ready drops only once the output register and stage 1 hold.
module framed_command_receiver_drive_mixer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	fcr_in_if.sink      in_ch,
	fcr_out_if.source   out_ch
);
	import fcr_pkg::*;

	mix_cfg_t   cfg_q;
	parse_res_t prs;
	out_res_t   res;
	logic       s1_valid_q;
	logic       out_valid_q;
	logic       adv_out;
	logic       adv_s1;
	logic       in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BASE_DUTY:  cfg_q.base_duty  <= cfg_data;
				CFG_SPEED_GAIN: cfg_q.speed_gain <= cfg_data;
				CFG_TURN_GAIN:  cfg_q.turn_gain  <= cfg_data[7:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	assign adv_out     = !out_valid_q || out_ch.ready;
	assign adv_s1      = !s1_valid_q || adv_out;
	assign in_ch.ready = adv_s1;
	assign in_acc      = in_ch.valid && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				s1_valid_q <= in_acc;
			end
			if (adv_out) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	fcr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_acc),
		.rx_byte (in_ch.rx_byte),
		.res     (prs)
	);

	fcr_mixer u_mixer (
		.clk      (clk),
		.load_s1  (in_acc),
		.load_out (adv_out && s1_valid_q),
		.prs      (prs),
		.cfg      (cfg_q),
		.res      (res)
	);

	assign out_ch.valid           = out_valid_q;
	assign out_ch.frame_accepted  = res.prs.ok;
	assign out_ch.checksum_bad    = res.prs.bad;
	assign out_ch.cmd_direction   = res.prs.dir;
	assign out_ch.cmd_speed       = res.prs.spd;
	assign out_ch.cmd_height      = res.prs.hgt;
	assign out_ch.cmd_angle       = res.prs.ang;
	assign out_ch.motor_a_forward = res.a_fwd;
	assign out_ch.motor_a_reverse = res.a_rev;
	assign out_ch.motor_b_forward = res.b_fwd;
	assign out_ch.motor_b_reverse = res.b_rev;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.frame_accepted && out_ch.checksum_bad))
		else $error("frame flags both set");

	a_forward_no_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.cmd_speed[7] && out_ch.cmd_speed != 8'sd0)
		|-> (out_ch.motor_a_reverse == 16'd0 && out_ch.motor_b_reverse == 16'd0))
		else $error("reverse channel driven while moving forward");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && adv_out) |=> out_valid_q)
		else $error("stage 1 item lost");

	a_idle_all_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.cmd_speed == 8'sd0 && out_ch.cmd_direction == 8'sd0)
		|-> (out_ch.motor_a_forward == 16'd0 && out_ch.motor_b_forward == 16'd0))
		else $error("motor driven with zero command");

endmodule

FILE: bench/fcr_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker: watches the byte and result channels and the config port, tracks
// the frame parser and drive mixer state, and compares every result item in order.
// Depends on fcr_pkg and fcr_stream_if.
module fcr_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	fcr_in_if           in_ch,
	fcr_out_if          out_ch,
	output int          fail_count,
	output int          pending
);
	import fcr_pkg::*;

	typedef struct packed {
		logic        ok;
		logic        bad;
		logic [7:0]  dir;
		logic [7:0]  spd;
		logic [7:0]  hgt;
		logic [7:0]  ang;
		logic [15:0] a_fwd;
		logic [15:0] a_rev;
		logic [15:0] b_fwd;
		logic [15:0] b_rev;
	} drive_cmd_t;

	phase_t      frame_phase;
	logic [7:0]  payload [4];
	logic [7:0]  dir_q, spd_q, hgt_q, ang_q;
	logic [15:0] base_duty_q, speed_gain_q;
	logic [7:0]  turn_gain_q;
	drive_cmd_t  expected_cmds [$];
	int          accepted_bytes;
	int          returned_cmds;

	assign pending = accepted_bytes - returned_cmds;

	function automatic logic [15:0] saturate_duty(input int v);
		if (v < 0) return 16'h0000;
		if (v > 65535) return 16'hFFFF;
		return v[15:0];
	endfunction

	task automatic parse_and_mix(input logic [7:0] b, output drive_cmd_t r);
		int spd, dir, sterm, tterm, base;
		logic [7:0] sum;
		r = '0;
		case (frame_phase)
			PH_HUNT_S: frame_phase = (b == HDR_FIRST) ? PH_WAIT_W : PH_HUNT_S;
			PH_WAIT_W: begin
				if (b == HDR_SECOND) frame_phase = PH_BYTE0;
				else if (b != HDR_FIRST) frame_phase = PH_HUNT_S;
			end
			PH_BYTE0, PH_BYTE1, PH_BYTE2, PH_BYTE3: begin
				payload[int'(frame_phase) - int'(PH_BYTE0)] = b;
				frame_phase = phase_t'(frame_phase + 3'd1);
			end
			PH_SUM: begin
				sum = payload[0] + payload[1] + payload[2] + payload[3];
				if (sum == b) begin
					dir_q = payload[0];
					spd_q = payload[1];
					hgt_q = payload[2];
					ang_q = payload[3];
					r.ok = 1'b1;
				end else begin
					r.bad = 1'b1;
				end
				frame_phase = PH_HUNT_S;
			end
			default: frame_phase = PH_HUNT_S;
		endcase
		spd = $signed(spd_q);
		dir = $signed(dir_q);
		base = int'(base_duty_q);
		sterm = spd * int'(speed_gain_q);
		tterm = dir * int'(turn_gain_q);
		if (spd > 0) begin
			r.a_fwd = saturate_duty(base + sterm + tterm);
			r.b_fwd = saturate_duty(base + sterm - tterm);
		end else if (spd < 0) begin
			r.a_rev = saturate_duty(base - sterm + tterm);
			r.b_rev = saturate_duty(base - sterm - tterm);
		end else if (dir > 0) begin
			r.a_rev = saturate_duty(base + tterm);
			r.b_fwd = saturate_duty(base + tterm);
		end else if (dir < 0) begin
			r.a_fwd = saturate_duty(base - tterm);
			r.b_rev = saturate_duty(base - tterm);
		end
		r.dir = dir_q;
		r.spd = spd_q;
		r.hgt = hgt_q;
		r.ang = ang_q;
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			if (fail_count < 10)
				$display("mismatch %s: expected %h, got %h at %0t", name, want, got, $realtime);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		drive_cmd_t want;
		if (!arst_n) begin
			frame_phase = PH_HUNT_S;
			payload = '{default: 8'h00};
			dir_q = '0;
			spd_q = '0;
			hgt_q = '0;
			ang_q = '0;
			base_duty_q = '0;
			speed_gain_q = '0;
			turn_gain_q = '0;
			expected_cmds.delete();
			fail_count = 0;
			accepted_bytes <= 0;
			returned_cmds <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BASE_DUTY:  base_duty_q = cfg_data;
					CFG_SPEED_GAIN: speed_gain_q = cfg_data;
					CFG_TURN_GAIN:  turn_gain_q = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				returned_cmds <= returned_cmds + 1;
				if (expected_cmds.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item at %0t", $realtime);
					fail_count++;
				end else begin
					want = expected_cmds.pop_front();
					compare_field("frame_accepted", {15'd0, want.ok},
						{15'd0, out_ch.frame_accepted});
					compare_field("checksum_bad", {15'd0, want.bad},
						{15'd0, out_ch.checksum_bad});
					compare_field("cmd_direction", {8'h00, want.dir},
						{8'h00, out_ch.cmd_direction});
					compare_field("cmd_speed", {8'h00, want.spd}, {8'h00, out_ch.cmd_speed});
					compare_field("cmd_height", {8'h00, want.hgt}, {8'h00, out_ch.cmd_height});
					compare_field("cmd_angle", {8'h00, want.ang}, {8'h00, out_ch.cmd_angle});
					compare_field("motor_a_forward", want.a_fwd, out_ch.motor_a_forward);
					compare_field("motor_a_reverse", want.a_rev, out_ch.motor_a_reverse);
					compare_field("motor_b_forward", want.b_fwd, out_ch.motor_b_forward);
					compare_field("motor_b_reverse", want.b_rev, out_ch.motor_b_reverse);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				parse_and_mix(in_ch.rx_byte, want);
				expected_cmds.push_back(want);
				accepted_bytes <= accepted_bytes + 1;
			end
		end
	end
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the receiver bench: clock, reset, config writes, byte stimulus and result stalls.
// Depends on fcr_pkg, fcr_stream_if, the receiver top level and fcr_frame_checker.
module tb_top;
	import fcr_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int BYTE_TARGET = 1900;
	localparam int NUM_PHASES = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;
	int          bytes_sent;
	int          hold_requests;
	int          cycle_count;
	bit          send_idle;
	bit          recv_idle;

	fcr_in_if  in_ch ();
	fcr_out_if out_ch ();

	framed_command_receiver_drive_mixer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	fcr_frame_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.rx_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		bytes_sent++;
		gap = (send_idle && $urandom_range(0, 99) < 30) ? gap_length() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			in_ch.rx_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic [7:0] dir, input logic [7:0] spd,
			input logic [7:0] hgt, input logic [7:0] ang, input logic [7:0] corrupt);
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		send_byte(dir);
		send_byte(spd);
		send_byte(hgt);
		send_byte(ang);
		send_byte((dir + spd + hgt + ang) ^ corrupt);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [15:0] base, input logic [15:0] sgain,
			input logic [7:0] tgain);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BASE_DUTY;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= CFG_SPEED_GAIN;
		cfg_data <= sgain;
		@(posedge clk);
		cfg_index <= CFG_TURN_GAIN;
		cfg_data <= {8'h00, tgain};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] command_byte(input int zero_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < zero_pct) return 8'h00;
		if (r < zero_pct + 5) return 8'h7F;
		if (r < zero_pct + 10) return 8'h80;
		return 8'($urandom);
	endfunction

	task automatic send_random_sequence();
		int kind;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 4)) begin
				b = ($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom);
				send_byte(b);
			end
		end else if (kind < 18) begin
			send_byte(HDR_FIRST);
			do b = 8'($urandom); while (b == HDR_SECOND || b == HDR_FIRST);
			send_byte(b);
		end else begin
			if (kind < 26)
				repeat ($urandom_range(1, 3)) send_byte(HDR_FIRST);
			send_frame(command_byte(20), command_byte(25), 8'($urandom), 8'($urandom),
				(kind < 36) ? 8'($urandom_range(1, 255)) : 8'h00);
		end
	endtask

	initial begin : result_sink
		int stall_left;
		int holds_done;
		stall_left = 0;
		holds_done = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				stall_left = 400;
			end else if (stall_left == 0 && recv_idle && $urandom_range(0, 99) < 20) begin
				stall_left = gap_length();
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_DUTY;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.rx_byte = '0;
		bytes_sent = 0;
		hold_requests = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturating gains with the extreme command bytes
		write_config(16'hFFFF, 16'hFFFF, 8'hFF);
		send_byte(HDR_FIRST);
		send_frame(8'h80, 8'h7F, 8'h00, 8'hFF, 8'h00);
		send_byte(HDR_FIRST);
		send_byte(8'h00);
		send_frame(8'h01, 8'h81, 8'h7F, 8'h80, 8'h5A);
		send_frame(8'h7F, 8'h00, 8'h12, 8'h34, 8'h00);

		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				0: write_config(16'h0000, 16'h0000, 8'h00);
				1: write_config(16'hFFFF, 16'hFFFF, 8'hFF);
				2: write_config(16'h0000, 16'($urandom_range(0, 500)), 8'hFF);
				default: write_config(
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500)),
					8'($urandom));
			endcase
			send_idle <= ((p % 3) != 1) && (p != 3);
			recv_idle <= (p % 4) != 2;
			if (p == 3) begin
				hold_requests <= hold_requests + 1;
			end
			@(posedge clk);
			while (bytes_sent < (p + 1) * BYTE_TARGET / NUM_PHASES)
				send_random_sequence();
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/fcr_pkg.sv
hw/rtl/fcr_stream_if.sv
hw/rtl/fcr_parser.sv
hw/rtl/fcr_mixer.sv
hw/rtl/framed_command_receiver_drive_mixer_top.sv
bench/fcr_frame_checker.sv
bench/tb_top.sv
